// ===== hw/rtl/wstf_pkg.sv =====
// Shared types and constants for the WebSocket transmit framer.
// Holds the item structs, the internal command struct and header byte constants.
// No dependencies.
`timescale 1ns / 1ps

package wstf_pkg;

    localparam logic [7:0] FIN_BIT    = 8'h80;
    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [7:0] LEN7_MAX   = 8'h7d;
    localparam logic [7:0] LEN16_CODE = 8'h7e;
    localparam logic [7:0] LEN64_CODE = 8'h7f;
    localparam logic [63:0] LEN16_MAX = 64'h0000_0000_0000_ffff;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // index of the last header byte for each length form
    localparam logic [3:0] HDR_LAST_SHORT = 4'd5;
    localparam logic [3:0] HDR_LAST_MID   = 4'd7;
    localparam logic [3:0] HDR_LAST_LONG  = 4'd13;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_MID   = 2'd1,
        LEN_LONG  = 2'd2
    } t_len_class;

    typedef struct packed {
        logic        operation;
        logic [3:0]  frame_opcode;
        logic [63:0] payload_length;
        logic [31:0] mask_key;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       overflow;
    } t_out_item;

    // one queue entry: a whole header, or one finished payload result
    typedef struct packed {
        logic        is_hdr;
        t_len_class  len_class;
        logic [3:0]  opcode;
        logic [63:0] plen;
        logic [31:0] key;
        logic [7:0]  data;
        logic        frame_end;
        logic        overflow;
    } t_cmd;

endpackage

// ===== hw/rtl/websocket_tx_framer_unit.sv =====
// Usage:
//   Client-side WebSocket frame encoder. Input channel push/full carries
//   t_in_item transfers: a start item (operation 0) with opcode, payload
//   length and mask key, or a payload byte (operation 1).
//   Result channel empty/pop carries t_out_item transfers: the framed byte
//   stream with run_last, frame_end and overflow flags.
//   A start item yields 6, 8 or 14 header bytes (7-bit, 16-bit or 64-bit
//   length form); a payload byte yields one masked byte.
//   Path: with nothing queued ahead, the first result of an item is written
//   into the command queue and then loaded into the output register.
//   Throughput: one result byte per cycle while pop is high, set by the
//   single byte sequencer in the back end; payload bytes then sustain one
//   item per cycle, and the queue (QUEUE_DEPTH entries) absorbs items while a header drains.
//   Reset (synchronous, active low) clears mask, byte count and phase, and
//   empties the queue and the output register.
//   When the receiver holds pop low the result stays put, the queue fills,
//   and full rises once QUEUE_DEPTH commands are waiting.
// Depends on wstf_pkg, wstf_front, wstf_queue, wstf_back.
`timescale 1ns / 1ps

module websocket_tx_framer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  wstf_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output wstf_pkg::t_out_item o_out_item
);
    import wstf_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    t_cmd head;
    logic q_empty;
    logic q_full;
    logic head_rd;

    assign full = q_full;

    wstf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    wstf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_valid),
        .i_wr_data (cmd),
        .i_rd      (head_rd),
        .o_head    (head),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    wstf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (q_empty),
        .o_head_rd    (head_rd),
        .i_res_pop    (pop),
        .o_res_empty  (empty),
        .o_out_item   (o_out_item)
    );

endmodule

// ===== hw/rtl/wstf_front.sv =====
// Front end: accepts input items, tracks frame state and masks payload bytes.
// Emits one command per accepted item. Depends on wstf_pkg.
`timescale 1ns / 1ps

module wstf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wstf_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_cmd_valid,
    output wstf_pkg::t_cmd    o_cmd
);
    import wstf_pkg::*;

    logic [31:0] r_mask, n_mask;
    logic [63:0] r_rem, n_rem;
    logic [1:0]  r_phase, n_phase;
    logic        accept;
    logic        rem_zero;
    logic [7:0]  mask_byte;

    assign accept      = i_push && !i_q_full;
    assign o_cmd_valid = accept;
    assign rem_zero    = (r_rem == 64'd0);
    assign mask_byte   = r_mask[{r_phase, 3'b000} +: 8];

    always_comb begin
        n_mask  = r_mask;
        n_rem   = r_rem;
        n_phase = r_phase;
        o_cmd           = '0;
        o_cmd.opcode    = i_in_item.frame_opcode;
        o_cmd.plen      = i_in_item.payload_length;
        o_cmd.key       = i_in_item.mask_key;
        o_cmd.len_class = LEN_SHORT;
        if (i_in_item.operation == OP_START) begin
            o_cmd.is_hdr    = 1'b1;
            o_cmd.frame_end = (i_in_item.payload_length == 64'd0);
            if (i_in_item.payload_length <= {56'd0, LEN7_MAX}) begin
                o_cmd.len_class = LEN_SHORT;
            end else if (i_in_item.payload_length <= LEN16_MAX) begin
                o_cmd.len_class = LEN_MID;
            end else begin
                o_cmd.len_class = LEN_LONG;
            end
            if (accept) begin
                n_mask  = i_in_item.mask_key;
                n_rem   = i_in_item.payload_length;
                n_phase = 2'd0;
            end
        end else if (rem_zero) begin
            o_cmd.overflow = 1'b1;
        end else begin
            o_cmd.data      = i_in_item.data_byte ^ mask_byte;
            o_cmd.frame_end = (r_rem == 64'd1);
            if (accept) begin
                n_rem   = r_rem - 64'd1;
                n_phase = r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_rem   <= '0;
            r_phase <= '0;
        end else begin
            r_mask  <= n_mask;
            r_rem   <= n_rem;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTH
    a_phase_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.operation == OP_START) |=> (r_phase == 2'd0))
        else $error("mask phase not restarted by a frame start");
    a_ovf_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_cmd.overflow) |=> ($stable(r_rem) && $stable(r_phase)))
        else $error("overflow byte changed frame state");
    a_end_on_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !o_cmd.is_hdr && o_cmd.frame_end) |=> (r_rem == 64'd0))
        else $error("frame end flagged with bytes remaining");
`endif

endmodule

// ===== hw/rtl/wstf_queue.sv =====
// Command queue between the front end and the byte sequencer.
// Register-based circular buffer of wstf_pkg::t_cmd entries.
`timescale 1ns / 1ps

module wstf_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wstf_pkg::t_cmd i_wr_data,
    input  logic           i_rd,
    output wstf_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import wstf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("write into full command queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("read from empty command queue");
`endif

endmodule

// ===== hw/rtl/wstf_back.sv =====
// Back end: walks each queued command byte by byte into the output register.
// Headers yield 6, 8 or 14 bytes, payload results one. Depends on wstf_pkg.
`timescale 1ns / 1ps

module wstf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wstf_pkg::t_cmd      i_head,
    input  logic                i_head_empty,
    output logic                o_head_rd,
    input  logic                i_res_pop,
    output logic                o_res_empty,
    output wstf_pkg::t_out_item o_out_item
);
    import wstf_pkg::*;

    logic [3:0] r_idx, n_idx;
    logic       r_valid;
    t_out_item  r_out;
    t_out_item  cur;
    logic [3:0] last_idx;
    logic       is_last;
    logic       adv;
    logic [7:0] hdr_byte;
    logic [1:0] key_sel;
    logic [2:0] len_sel;

    assign adv         = !i_head_empty && (!r_valid || i_res_pop);
    assign o_res_empty = !r_valid;
    assign o_out_item  = r_out;

    always_comb begin
        unique case (i_head.len_class)
            LEN_SHORT: last_idx = HDR_LAST_SHORT;
            LEN_MID:   last_idx = HDR_LAST_MID;
            LEN_LONG:  last_idx = HDR_LAST_LONG;
            default:   last_idx = HDR_LAST_SHORT;
        endcase
        if (!i_head.is_hdr) begin
            last_idx = 4'd0;
        end
    end

    assign is_last   = (r_idx == last_idx);
    assign o_head_rd = adv && is_last;

    always_comb begin
        key_sel  = 2'(r_idx - 4'd2);
        len_sel  = 3'(4'd9 - r_idx);
        hdr_byte = '0;
        if (r_idx == 4'd0) begin
            hdr_byte = FIN_BIT | {4'd0, i_head.opcode};
        end else begin
            unique case (i_head.len_class)
                LEN_SHORT: begin
                    if (r_idx == 4'd1) begin
                        hdr_byte = MASK_BIT | {1'b0, i_head.plen[6:0]};
                    end else begin
                        hdr_byte = i_head.key[{key_sel, 3'b000} +: 8];
                    end
                end
                LEN_MID: begin
                    key_sel = r_idx[1:0];
                    if (r_idx == 4'd1) begin
                        hdr_byte = MASK_BIT | LEN16_CODE;
                    end else if (r_idx == 4'd2) begin
                        hdr_byte = i_head.plen[15:8];
                    end else if (r_idx == 4'd3) begin
                        hdr_byte = i_head.plen[7:0];
                    end else begin
                        hdr_byte = i_head.key[{key_sel, 3'b000} +: 8];
                    end
                end
                LEN_LONG: begin
                    key_sel = 2'(r_idx + 4'd2);
                    if (r_idx == 4'd1) begin
                        hdr_byte = MASK_BIT | LEN64_CODE;
                    end else if (r_idx <= 4'd9) begin
                        hdr_byte = i_head.plen[{len_sel, 3'b000} +: 8];
                    end else begin
                        hdr_byte = i_head.key[{key_sel, 3'b000} +: 8];
                    end
                end
                default: hdr_byte = '0;
            endcase
        end
    end

    always_comb begin
        if (i_head.is_hdr) begin
            cur.out_byte  = hdr_byte;
            cur.run_last  = is_last;
            cur.frame_end = is_last && i_head.frame_end;
            cur.overflow  = 1'b0;
        end else begin
            cur.out_byte  = i_head.data;
            cur.run_last  = 1'b1;
            cur.frame_end = i_head.frame_end;
            cur.overflow  = i_head.overflow;
        end
        n_idx = r_idx;
        if (adv) begin
            n_idx = is_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (adv) begin
                r_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= cur;
        end
    end

`ifndef SYNTH
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_empty |-> (r_idx == 4'd0))
        else $error("byte index moved with no command queued");
    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.overflow) |->
            (r_out.run_last && !r_out.frame_end && r_out.out_byte == 8'd0))
        else $error("malformed overflow result");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.frame_end) |-> r_out.run_last)
        else $error("frame end without run last");
`endif

endmodule
